[hw/rtl/checked_buffer_pool_allocator_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the checked buffer pool allocator
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CHECKED_BUFFER_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define CHECKED_BUFFER_POOL_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CBPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBPA_ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBPA_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define CBPA_ASSERT_ON(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/cbpa_pkg.sv]
// ----------------------------------------------------------------------------
// Checked buffer pool allocator package
// Pool geometry, opcodes, per-buffer record layout, its reset value and the sequencer state type.
// ----------------------------------------------------------------------------
package cbpa_pkg;

  localparam int POOL_SIZE = 16;
  localparam int LINK_W    = 8;
  localparam int ADDR_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W     = 8;
  localparam int FAIL_W    = 32;

  localparam logic [LINK_W-1:0] POOL_LINK = LINK_W'(POOL_SIZE);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              used;
    logic [CNT_W-1:0]  alloc_cnt;
    logic [CNT_W-1:0]  free_cnt;
  } entry_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  function automatic entry_t reset_entry(input logic [ADDR_W-1:0] addr);
    entry_t e;
    e.link      = LINK_W'(addr) + LINK_W'(1);
    e.used      = 1'b0;
    e.alloc_cnt = '0;
    e.free_cnt  = '0;
    return e;
  endfunction

endpackage

[hw/rtl/checked_buffer_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// Checked buffer pool allocator core
// LIFO free list of buffer indices with allocate and checked free.
// ----------------------------------------------------------------------------
// The input channel carries one request per transaction: an allocate, or a
// free of buf_index with the raw transmit and queued-for-transmit flags.
// Every request yields exactly one result transaction on the output channel
// with the grant, the error flags and the used count after the request.
// All per-buffer state (next link, in-use mark, allocation and free tallies)
// sits in one single-port synchronous memory with registered read data.
// A request is accepted in the idle state and its record is read; in the
// execute state that follows, the record is updated, written back and the
// result is registered once the result register is free. A new request is
// accepted only after the execute state of the previous one has completed.
// The result register lets a new request be accepted while a result waits.
// If the receiver stalls and a second request has been read, that request
// holds in its execute cycle until the result register frees.
// Reset restores the full free list at once: per-entry valid flags make an
// unwritten record read as its reset value, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "checked_buffer_pool_allocator_core_defines.svh"

module checked_buffer_pool_allocator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_buf_index,
  input  logic       in_is_raw_tx_buffer,
  input  logic       in_queued_in_mac_fifo,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_alloc_ok,
  output logic [7:0] out_granted_index,
  output logic       out_err_out_of_pool,
  output logic       out_err_multi_free,
  output logic       out_err_pool_inconsistent,
  output logic [7:0] out_used_count_now
);

  cbpa_pkg::state_t state_r, state_nxt;

  cbpa_pkg::entry_t mem [cbpa_pkg::POOL_SIZE];
  cbpa_pkg::entry_t rd_data_r;
  logic             mem_we;
  cbpa_pkg::entry_t wr_data;

  logic [cbpa_pkg::POOL_SIZE-1:0] vld_r, vld_nxt;

  logic                          op_r;
  logic [7:0]                    idx_r;
  logic                          raw_r;
  logic                          queued_r;
  logic [cbpa_pkg::ADDR_W-1:0]   addr_r;
  logic [cbpa_pkg::ADDR_W-1:0]   rd_addr;

  logic [cbpa_pkg::LINK_W-1:0]   list_head_r, list_head_nxt;
  logic                          head_valid_r, head_valid_nxt;
  logic [7:0]                    used_total_r, used_total_nxt;
  logic [cbpa_pkg::FAIL_W-1:0]   fail_total_r, fail_total_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          ok_r, ok_nxt;
  logic [7:0]                    granted_r, granted_nxt;
  logic                          oop_r, oop_nxt;
  logic                          multi_r, multi_nxt;
  logic                          incons_r, incons_nxt;

  logic                          accept;
  logic                          exec_go;
  cbpa_pkg::entry_t              cur;
  logic [cbpa_pkg::CNT_W-1:0]    free_inc;

  assign accept  = in_valid && in_ready;
  assign exec_go = (state_r == cbpa_pkg::ST_EXEC) && (!out_valid_r || out_ready);
  assign rd_addr = (in_operation == cbpa_pkg::OP_ALLOC) ?
                   list_head_r[cbpa_pkg::ADDR_W-1:0] :
                   in_buf_index[cbpa_pkg::ADDR_W-1:0];
  assign cur     = vld_r[addr_r] ? rd_data_r : cbpa_pkg::reset_entry(addr_r);
  assign free_inc = cur.free_cnt + cbpa_pkg::CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      cbpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = cbpa_pkg::ST_EXEC;
        end
      end
      cbpa_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt = cbpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cbpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    list_head_nxt  = list_head_r;
    head_valid_nxt = head_valid_r;
    used_total_nxt = used_total_r;
    fail_total_nxt = fail_total_r;
    vld_nxt        = vld_r;
    mem_we         = 1'b0;
    wr_data        = cur;
    out_valid_nxt  = out_valid_r && !out_ready;
    ok_nxt         = ok_r;
    granted_nxt    = granted_r;
    oop_nxt        = oop_r;
    multi_nxt      = multi_r;
    incons_nxt     = incons_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = 1'b0;
      granted_nxt   = '0;
      oop_nxt       = 1'b0;
      multi_nxt     = 1'b0;
      incons_nxt    = 1'b0;
      if (op_r == cbpa_pkg::OP_ALLOC) begin
        if (used_total_r < cbpa_pkg::POOL_LINK && head_valid_r &&
            list_head_r < cbpa_pkg::POOL_LINK) begin
          if (cur.link < cbpa_pkg::POOL_LINK) begin
            list_head_nxt  = cur.link;
            head_valid_nxt = 1'b1;
          end else begin
            list_head_nxt  = '0;
            head_valid_nxt = 1'b0;
          end
          wr_data.link      = cbpa_pkg::POOL_LINK;
          wr_data.used      = 1'b1;
          wr_data.alloc_cnt = cur.alloc_cnt + cbpa_pkg::CNT_W'(1);
          mem_we            = 1'b1;
          vld_nxt[addr_r]   = 1'b1;
          used_total_nxt    = used_total_r + 8'd1;
          ok_nxt            = 1'b1;
          granted_nxt       = 8'(list_head_r);
        end else begin
          incons_nxt     = used_total_r < cbpa_pkg::POOL_LINK;
          fail_total_nxt = fail_total_r + cbpa_pkg::FAIL_W'(1);
        end
      end else begin
        ok_nxt = 1'b1;
        if (!raw_r) begin
          if (idx_r >= cbpa_pkg::POOL_LINK) begin
            oop_nxt = 1'b1;
          end else begin
            multi_nxt        = queued_r || (free_inc > cur.alloc_cnt) || !cur.used;
            wr_data.free_cnt = free_inc;
            wr_data.used     = 1'b0;
            wr_data.link     = head_valid_r ? list_head_r : cbpa_pkg::POOL_LINK;
            mem_we           = 1'b1;
            vld_nxt[addr_r]  = 1'b1;
            list_head_nxt    = idx_r;
            head_valid_nxt   = 1'b1;
            used_total_nxt   = used_total_r - 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      idx_r    <= in_buf_index;
      raw_r    <= in_is_raw_tx_buffer;
      queued_r <= in_queued_in_mac_fifo;
      addr_r   <= rd_addr;
    end
    ok_r      <= ok_nxt;
    granted_r <= granted_nxt;
    oop_r     <= oop_nxt;
    multi_r   <= multi_nxt;
    incons_r  <= incons_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cbpa_pkg::ST_IDLE;
      vld_r        <= '0;
      list_head_r  <= '0;
      head_valid_r <= 1'b1;
      used_total_r <= '0;
      fail_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      list_head_r  <= list_head_nxt;
      head_valid_r <= head_valid_nxt;
      used_total_r <= used_total_nxt;
      fail_total_r <= fail_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_alloc_ok              = ok_r;
  assign out_granted_index         = granted_r;
  assign out_err_out_of_pool       = oop_r;
  assign out_err_multi_free        = multi_r;
  assign out_err_pool_inconsistent = incons_r;
  assign out_used_count_now        = used_total_r;

  `CBPA_ASSERT_RST(a_accept_to_exec, clk, rst_n, accept |=> state_r == cbpa_pkg::ST_EXEC, "accepted transaction did not move to execute")
  `CBPA_ASSERT_RST(a_head_in_pool, clk, rst_n, head_valid_r |-> list_head_r < cbpa_pkg::POOL_LINK, "valid list head lies outside the pool")
  `CBPA_ASSERT_RST(a_empty_head_zero, clk, rst_n, !head_valid_r |-> list_head_r == '0, "empty free list with non-zero head")
  `CBPA_ASSERT_RST(a_grant_implies_ok, clk, rst_n, (out_valid_r && granted_r != 8'd0) |-> ok_r, "grant reported without success")
  `CBPA_ASSERT_RST(a_single_error, clk, rst_n, out_valid_r |-> $countones({oop_r, multi_r, incons_r}) <= 1, "more than one error class reported")
  `CBPA_ASSERT_ON(a_write_in_exec, clk, mem_we |-> state_r == cbpa_pkg::ST_EXEC, "memory written outside execute")

endmodule

[tb/checked_buffer_pool_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the checked buffer pool allocator core
// Drives allocate and free requests through the valid/ready input channel and
// compares every result transaction with a cycle-free model of the free list,
// the per-buffer tallies and the used count. Covers pool exhaustion, a broken
// list, multi-frees, out-of-pool and raw transmit frees, count underflow and
// rapid reuse of one buffer, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module checked_buffer_pool_allocator_core_tb;

  typedef struct packed {
    logic       ok;
    logic [7:0] granted;
    logic       oop;
    logic       multi;
    logic       incons;
    logic [7:0] used;
  } pool_result_t;

  class pool_scoreboard;
    logic [cbpa_pkg::LINK_W-1:0] link [cbpa_pkg::POOL_SIZE];
    logic                        in_use [cbpa_pkg::POOL_SIZE];
    logic [cbpa_pkg::CNT_W-1:0]  alloc_tally [cbpa_pkg::POOL_SIZE];
    logic [cbpa_pkg::CNT_W-1:0]  free_tally [cbpa_pkg::POOL_SIZE];
    logic [cbpa_pkg::LINK_W-1:0] head;
    logic                        head_valid;
    logic [7:0]                  used_total;
    logic [cbpa_pkg::FAIL_W-1:0] fail_total;
    logic [7:0]                  last_grant;
    pool_result_t                pending_outcomes[$];
    int unsigned                 mismatches, checked_cnt, granted_cnt, incons_cnt;
    int unsigned                 free_cnt, multi_cnt, oop_cnt, raw_cnt;

    function new();
      for (int i = 0; i < cbpa_pkg::POOL_SIZE; i++) begin
        link[i]        = cbpa_pkg::LINK_W'(i + 1);
        in_use[i]      = 1'b0;
        alloc_tally[i] = '0;
        free_tally[i]  = '0;
      end
      head       = '0;
      head_valid = 1'b1;
      used_total = '0;
      fail_total = '0;
      last_grant = '0;
    endfunction

    function void note_request(logic op, logic [7:0] idx, logic raw, logic queued);
      pool_result_t res;
      logic [cbpa_pkg::LINK_W-1:0] h;
      logic [cbpa_pkg::LINK_W-1:0] nx;
      res = '0;
      if (op == cbpa_pkg::OP_ALLOC) begin
        if (used_total < cbpa_pkg::POOL_SIZE && head_valid &&
            head < cbpa_pkg::POOL_SIZE) begin
          h  = head;
          nx = link[h];
          if (nx < cbpa_pkg::POOL_SIZE) begin
            head = nx;
          end else begin
            head       = '0;
            head_valid = 1'b0;
          end
          link[h]        = cbpa_pkg::POOL_LINK;
          in_use[h]      = 1'b1;
          alloc_tally[h] = alloc_tally[h] + 1'b1;
          used_total     = used_total + 1'b1;
          res.ok         = 1'b1;
          res.granted    = h;
          last_grant     = h;
          granted_cnt++;
        end else begin
          res.incons = (used_total < cbpa_pkg::POOL_SIZE);
          fail_total = fail_total + 1'b1;
        end
      end else begin
        res.ok = 1'b1;
        free_cnt++;
        if (raw) begin
          raw_cnt++;
        end else if (idx >= cbpa_pkg::POOL_SIZE) begin
          res.oop = 1'b1;
        end else begin
          free_tally[idx] = free_tally[idx] + 1'b1;
          res.multi = queued || (free_tally[idx] > alloc_tally[idx]) || !in_use[idx];
          link[idx]   = head_valid ? head : cbpa_pkg::POOL_LINK;
          head        = idx;
          head_valid  = 1'b1;
          used_total  = used_total - 1'b1;
          in_use[idx] = 1'b0;
        end
      end
      res.used = used_total;
      if (res.incons) incons_cnt++;
      if (res.multi) multi_cnt++;
      if (res.oop) oop_cnt++;
      pending_outcomes.push_back(res);
    endfunction

    function void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_response(pool_result_t got);
      pool_result_t exp_res;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none expected, actual %h", $time, got);
        return;
      end
      exp_res = pending_outcomes.pop_front();
      checked_cnt++;
      check_field("alloc_ok", 8'(exp_res.ok), 8'(got.ok));
      check_field("granted_index", exp_res.granted, got.granted);
      check_field("err_out_of_pool", 8'(exp_res.oop), 8'(got.oop));
      check_field("err_multi_free", 8'(exp_res.multi), 8'(got.multi));
      check_field("err_pool_inconsistent", 8'(exp_res.incons), 8'(got.incons));
      check_field("used_count_now", exp_res.used, got.used);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_operation = cbpa_pkg::OP_ALLOC;
  logic [7:0] in_buf_index = '0;
  logic       in_is_raw_tx_buffer = 1'b0;
  logic       in_queued_in_mac_fifo = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_alloc_ok;
  logic [7:0] out_granted_index;
  logic       out_err_out_of_pool;
  logic       out_err_multi_free;
  logic       out_err_pool_inconsistent;
  logic [7:0] out_used_count_now;

  pool_scoreboard pool_sb;
  int unsigned    src_idle_pct = 30;
  int unsigned    sink_idle_pct = 57;
  int unsigned    phase_no = 1;
  int unsigned    wraps_left = 0;

  checked_buffer_pool_allocator_core DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_operation              (in_operation),
    .in_buf_index              (in_buf_index),
    .in_is_raw_tx_buffer       (in_is_raw_tx_buffer),
    .in_queued_in_mac_fifo     (in_queued_in_mac_fifo),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_alloc_ok              (out_alloc_ok),
    .out_granted_index         (out_granted_index),
    .out_err_out_of_pool       (out_err_out_of_pool),
    .out_err_multi_free        (out_err_multi_free),
    .out_err_pool_inconsistent (out_err_pool_inconsistent),
    .out_used_count_now        (out_used_count_now)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver holds off once for a long stretch at the start of the third phase.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (phase_no == 3 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pool_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_alloc_ok, out_granted_index, out_err_out_of_pool, out_err_multi_free,
              out_err_pool_inconsistent, out_used_count_now};
      pool_sb.check_response(got);
    end
  end

  task automatic send_request(input logic op, input logic [7:0] idx, input logic raw,
                              input logic queued);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_operation          <= op;
    in_buf_index          <= idx;
    in_is_raw_tx_buffer   <= raw;
    in_queued_in_mac_fifo <= queued;
    do @(posedge clk); while (!in_ready);
    pool_sb.note_request(op, idx, raw, queued);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pool_sb.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: allocate, and free buffers that are held. The rest
  // is raw, out-of-pool and stray in-pool frees with random flags.
  task automatic pick_request(input bit churn, output logic op, output logic [7:0] idx,
                              output logic raw, output logic queued);
    int unsigned roll;
    int unsigned held[$];
    roll   = $urandom_range(99);
    op     = cbpa_pkg::OP_ALLOC;
    idx    = 8'($urandom);
    raw    = 1'($urandom);
    queued = 1'($urandom);
    for (int i = 0; i < cbpa_pkg::POOL_SIZE; i++) begin
      if (pool_sb.in_use[i]) held.push_back(i);
    end
    if (roll < 12) begin
      op = cbpa_pkg::OP_FREE;
      case ($urandom_range(2))
        0: raw = 1'b1;
        1: begin
          raw = 1'b0;
          idx = 8'($urandom_range(255, cbpa_pkg::POOL_SIZE));
        end
        default: begin
          raw = 1'b0;
          idx = 8'($urandom_range(cbpa_pkg::POOL_SIZE - 1));
          if (pool_sb.used_total == 0) begin
            if (wraps_left == 0) op = cbpa_pkg::OP_ALLOC;
            else wraps_left--;
          end
        end
      endcase
    end else if (pool_sb.used_total >= cbpa_pkg::POOL_SIZE) begin
      if (roll < 90) begin
        op     = cbpa_pkg::OP_FREE;
        raw    = 1'b0;
        queued = 1'b0;
        idx    = (held.size() != 0) ? 8'(held[$urandom_range(held.size() - 1)])
                                    : 8'($urandom_range(cbpa_pkg::POOL_SIZE - 1));
      end
    end else if (churn) begin
      if (pool_sb.in_use[pool_sb.last_grant] && pool_sb.used_total != 0) begin
        op     = cbpa_pkg::OP_FREE;
        raw    = 1'b0;
        queued = 1'b0;
        idx    = pool_sb.last_grant;
      end
    end else if (held.size() != 0 && pool_sb.used_total != 0 && $urandom_range(1) == 1) begin
      op     = cbpa_pkg::OP_FREE;
      raw    = 1'b0;
      queued = 1'b0;
      idx    = 8'(held[$urandom_range(held.size() - 1)]);
    end
  endtask

  task automatic run_random(input int unsigned count, input bit churn);
    logic       op;
    logic [7:0] idx;
    logic       raw;
    logic       queued;
    repeat (count) begin
      pick_request(churn, op, idx, raw, queued);
      send_request(op, idx, raw, queued);
    end
  endtask

  initial begin
    pool_sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < cbpa_pkg::POOL_SIZE; i++) begin
      send_request(cbpa_pkg::OP_ALLOC, (i == 0) ? 8'hFF : 8'(i * 37), i[0], i[1]);
    end
    send_request(cbpa_pkg::OP_ALLOC, 8'h00, 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'd5, 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'd6, 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'd7, 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'd6, 1'b0, 1'b1);
    repeat (4) send_request(cbpa_pkg::OP_ALLOC, 8'h00, 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'hFF, 1'b1, 1'b1);
    send_request(cbpa_pkg::OP_FREE, 8'(cbpa_pkg::POOL_SIZE), 1'b0, 1'b0);
    send_request(cbpa_pkg::OP_FREE, 8'hFF, 1'b0, 1'b1);
    run_random(500, 1'b0);
    drain_results();

    src_idle_pct  = 57;
    sink_idle_pct = 30;
    phase_no      = 2;
    wraps_left    = 1;
    run_random(500, 1'b0);
    drain_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    phase_no      = 3;
    run_random(520, 1'b1);
    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d transactions: %0d grants, %0d failed allocations (%0d inconsistent).",
             pool_sb.checked_cnt, pool_sb.granted_cnt, pool_sb.fail_total, pool_sb.incons_cnt);
    $display("Frees: %0d in all, %0d multi-free, %0d out of pool, %0d raw transmit.",
             pool_sb.free_cnt, pool_sb.multi_cnt, pool_sb.oop_cnt, pool_sb.raw_cnt);
    if (pool_sb.mismatches == 0 && pool_sb.pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
